// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
// Both expect clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/pqe_pkg.sv =====
// ----------------------------------------------------------------------------
// pqe_pkg
// Shared types and constants of the polyline quad-strip expander.
// ----------------------------------------------------------------------------
package pqe_pkg;

  localparam int CoordW   = 32;
  localparam int ColorW   = 8;
  localparam int OffW     = 16;
  localparam int MagW     = 31;   // component magnitude after range shift
  localparam int RootW    = 32;
  localparam int QuotW    = 15;   // quotient never exceeds 16384
  localparam int NormFrac = 14;
  localparam int InDataW  = 88;
  localparam int OutDataW = 120;
  localparam int CntW     = 5;

  localparam logic [CntW-1:0] SqrtSteps = 5'd31;  // last count value
  localparam logic [CntW-1:0] DivSteps  = 5'd14;
  localparam logic [CntW-1:0] NumVerts  = 5'd5;
  localparam logic [QuotW-1:0] NormOne  = 15'd16384;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQX,
    ST_SQY,
    ST_SUM,
    ST_SQRT,
    ST_DINIT,
    ST_DIV,
    ST_EMIT
  } pqe_state_t;

  typedef struct packed {
    logic       capture;    // latch input point and color
    logic       first;      // input point becomes the previous point
    logic       diff;
    logic       sqx;
    logic       sqy;
    logic       sum;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       emit;       // load one vertex into the output register
    logic [2:0] vidx;
    logic       vlast;
  } pqe_cmd_t;

  typedef struct packed {
    logic out_busy;         // output register holds a vertex not taken this cycle
  } pqe_sts_t;

endpackage

// ===== sv/pqe_ctrl.sv =====
// ----------------------------------------------------------------------------
// pqe_ctrl
// Sequencer: accept, difference, squares, root, divide, six vertices.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pqe_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              line_start,
  input  pqe_pkg::pqe_sts_t sts_i,
  output pqe_pkg::pqe_cmd_t cmd_o
);

  pqe_pkg::pqe_state_t state_r, state_nxt;
  logic [pqe_pkg::CntW-1:0] cnt_r, cnt_nxt;
  logic have_prev_r, have_prev_nxt;
  logic acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pqe_pkg::ST_IDLE;
      cnt_r       <= '0;
      have_prev_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      have_prev_r <= have_prev_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    have_prev_nxt = have_prev_r;
    cmd_o         = '0;
    in_tready     = 1'b0;
    acc           = 1'b0;
    case (state_r)
      pqe_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        acc       = in_tvalid;
        if (acc) begin
          cmd_o.capture = 1'b1;
          if (line_start || !have_prev_r) begin
            cmd_o.first   = 1'b1;
            have_prev_nxt = 1'b1;
          end else begin
            state_nxt = pqe_pkg::ST_DIFF;
          end
        end
      end
      pqe_pkg::ST_DIFF: begin
        cmd_o.diff = 1'b1;
        state_nxt  = pqe_pkg::ST_SQX;
      end
      pqe_pkg::ST_SQX: begin
        cmd_o.sqx = 1'b1;
        state_nxt = pqe_pkg::ST_SQY;
      end
      pqe_pkg::ST_SQY: begin
        cmd_o.sqy = 1'b1;
        state_nxt = pqe_pkg::ST_SUM;
      end
      pqe_pkg::ST_SUM: begin
        cmd_o.sum = 1'b1;
        cnt_nxt   = '0;
        state_nxt = pqe_pkg::ST_SQRT;
      end
      pqe_pkg::ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_nxt         = cnt_r + 1'b1;
        if (cnt_r == pqe_pkg::SqrtSteps) begin
          state_nxt = pqe_pkg::ST_DINIT;
        end
      end
      pqe_pkg::ST_DINIT: begin
        cmd_o.div_init = 1'b1;
        cnt_nxt        = '0;
        state_nxt      = pqe_pkg::ST_DIV;
      end
      pqe_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_nxt        = cnt_r + 1'b1;
        if (cnt_r == pqe_pkg::DivSteps) begin
          cnt_nxt   = '0;
          state_nxt = pqe_pkg::ST_EMIT;
        end
      end
      pqe_pkg::ST_EMIT: begin
        cmd_o.vidx = cnt_r[2:0];
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          cnt_nxt    = cnt_r + 1'b1;
          if (cnt_r == pqe_pkg::NumVerts) begin
            cmd_o.vlast = 1'b1;
            state_nxt   = pqe_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = pqe_pkg::ST_IDLE;
    endcase
  end

  `ASSERT_IMPL(a_emit_no_overwrite, cmd_o.emit, !sts_i.out_busy)
  `ASSERT_IMPL(a_emit_count, state_r == pqe_pkg::ST_EMIT, cnt_r <= pqe_pkg::NumVerts)
  `ASSERT_NEXT(a_div_follows_root, cmd_o.div_init, state_r == pqe_pkg::ST_DIV && cnt_r == '0)

endmodule

// ===== sv/pqe_datapath.sv =====
// ----------------------------------------------------------------------------
// pqe_datapath
// Point registers, squares, digit-by-digit root, two divider lanes, vertex out.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pqe_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [pqe_pkg::InDataW-1:0]   in_tdata,
  input  pqe_pkg::pqe_cmd_t             cmd_i,
  output pqe_pkg::pqe_sts_t             sts_o,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [pqe_pkg::OutDataW-1:0]  out_tdata,
  output logic                          out_tlast
);

  localparam int NumW = pqe_pkg::MagW + pqe_pkg::NormFrac + 1;

  logic [pqe_pkg::CoordW-1:0] qx_r, qy_r, px_r, py_r;
  logic [3*pqe_pkg::ColorW-1:0] rgb_r;
  logic [pqe_pkg::MagW-1:0] ax_r, ay_r;
  logic nxneg_r, nyneg_r;
  logic [2*pqe_pkg::MagW-1:0] sqx_r, sqy_r;
  logic [63:0] rad_r;
  logic [33:0] srem_r;
  logic [pqe_pkg::RootW-1:0] root_r;
  logic [pqe_pkg::RootW-1:0] drem_r [2];
  logic [pqe_pkg::QuotW-1:0] dlo_r [2];
  logic [pqe_pkg::QuotW-1:0] quo_r [2];
  logic out_valid_r;
  logic [pqe_pkg::OutDataW-1:0] out_data_r;
  logic out_last_r;

  // difference and range shift
  logic [32:0] dx, dy, mx, my, mxs, mys;
  always_comb begin
    dx = {qx_r[31], qx_r} - {px_r[31], px_r};
    dy = {qy_r[31], qy_r} - {py_r[31], py_r};
    mx = dx[32] ? (33'd0 - dx) : dx;
    my = dy[32] ? (33'd0 - dy) : dy;
    if (mx[32] || my[32]) begin
      mxs = mx >> 2;
      mys = my >> 2;
    end else if (mx[31] || my[31]) begin
      mxs = mx >> 1;
      mys = my >> 1;
    end else begin
      mxs = mx;
      mys = my;
    end
  end

  // root step: two radicand bits per cycle
  logic [33:0] st, strial;
  always_comb begin
    st     = {srem_r[31:0], rad_r[63:62]};
    strial = {root_r, 2'b01};
  end

  // divider lanes: lane 0 gives |nx| from ay, lane 1 gives |ny| from ax
  logic [NumW-1:0] num [2];
  logic [pqe_pkg::RootW:0] dt [2];
  always_comb begin
    num[0] = {1'b0, ay_r, {pqe_pkg::NormFrac{1'b0}}} + NumW'(root_r >> 1);
    num[1] = {1'b0, ax_r, {pqe_pkg::NormFrac{1'b0}}} + NumW'(root_r >> 1);
    for (int i = 0; i < 2; i++) begin
      dt[i] = {drem_r[i], dlo_r[i][pqe_pkg::QuotW-1]};
    end
  end

  // vertex select
  logic at_q, kneg, zlen;
  logic [pqe_pkg::OffW-1:0] magx, magy, offx, offy;
  always_comb begin
    at_q = (cmd_i.vidx == 3'd1) || (cmd_i.vidx == 3'd4) || (cmd_i.vidx == 3'd5);
    kneg = (cmd_i.vidx == 3'd0) || (cmd_i.vidx == 3'd3) || (cmd_i.vidx == 3'd5);
    zlen = (root_r == '0);
    magx = zlen ? '0 : {1'b0, quo_r[0]};
    magy = zlen ? '0 : {1'b0, quo_r[1]};
    offx = (nxneg_r ^ kneg) ? (16'd0 - magx) : magx;
    offy = (nyneg_r ^ kneg) ? (16'd0 - magy) : magy;
  end

  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      qx_r  <= in_tdata[31:0];
      qy_r  <= in_tdata[63:32];
      rgb_r <= in_tdata[87:64];
      if (cmd_i.first) begin
        px_r <= in_tdata[31:0];
        py_r <= in_tdata[63:32];
      end
    end
    if (cmd_i.diff) begin
      ax_r    <= mxs[pqe_pkg::MagW-1:0];
      ay_r    <= mys[pqe_pkg::MagW-1:0];
      nxneg_r <= dy[32];
      nyneg_r <= !dx[32] && (dx != '0);
    end
    if (cmd_i.sqx) sqx_r <= ax_r * ax_r;
    if (cmd_i.sqy) sqy_r <= ay_r * ay_r;
    if (cmd_i.sum) begin
      // sum of squares needs 63 bits
      rad_r  <= 64'(sqx_r) + 64'(sqy_r);
      srem_r <= '0;
      root_r <= '0;
    end
    if (cmd_i.sqrt_step) begin
      rad_r <= {rad_r[61:0], 2'b00};
      if (st >= strial) begin
        srem_r <= st - strial;
        root_r <= {root_r[30:0], 1'b1};
      end else begin
        srem_r <= st;
        root_r <= {root_r[30:0], 1'b0};
      end
    end
    for (int i = 0; i < 2; i++) begin
      if (cmd_i.div_init) begin
        drem_r[i] <= {1'b0, num[i][NumW-1:pqe_pkg::QuotW]};
        dlo_r[i]  <= num[i][pqe_pkg::QuotW-1:0];
        quo_r[i]  <= '0;
      end
      if (cmd_i.div_step) begin
        dlo_r[i] <= {dlo_r[i][pqe_pkg::QuotW-2:0], 1'b0};
        if (dt[i] >= {1'b0, root_r}) begin
          drem_r[i] <= pqe_pkg::RootW'(dt[i] - {1'b0, root_r});
          quo_r[i]  <= {quo_r[i][pqe_pkg::QuotW-2:0], 1'b1};
        end else begin
          drem_r[i] <= dt[i][pqe_pkg::RootW-1:0];
          quo_r[i]  <= {quo_r[i][pqe_pkg::QuotW-2:0], 1'b0};
        end
      end
    end
    if (cmd_i.emit) begin
      out_data_r <= {rgb_r, offy, offx, (at_q ? qy_r : py_r), (at_q ? qx_r : px_r)};
      out_last_r <= cmd_i.vlast;
      if (cmd_i.vlast) begin
        px_r <= qx_r;
        py_r <= qy_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts_o.out_busy = out_valid_r && !out_tready;
  assign out_tvalid     = out_valid_r;
  assign out_tdata      = out_data_r;
  assign out_tlast      = out_last_r;

  // quotients are meaningless for a zero-length segment
  `ASSERT_IMPL(a_norm_bound, cmd_i.emit && !zlen, quo_r[0] <= pqe_pkg::NormOne && quo_r[1] <= pqe_pkg::NormOne)

endmodule

// ===== sv/polyline_to_quad_strip_expander_core.sv =====
// ----------------------------------------------------------------------------
// polyline_to_quad_strip_expander_core
// Expands polyline points into six-vertex quads with unit right normals.
// ----------------------------------------------------------------------------
// One request at a time. A point that opens a line (or arrives with no held
// point) is latched as the held point and yields nothing. Any other point goes
// through accept, difference, x and y squaring, sum, the two-bit-per-cycle
// square root, divider setup and the two parallel restoring dividers, then 6
// vertex loads, each waiting on out_tready, before the next request is taken.
// The root loop is the longest step. The sixth vertex of a segment carries
// out_tlast and may still wait in the output register while the next point
// is accepted.
module polyline_to_quad_strip_expander_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_x[31:0], pos_y[63:32], red[71:64], green[79:72], blue[87:80]
  input  logic [87:0]  in_tdata,
  // line_start
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // vert_x[31:0], vert_y[63:32], offset_x[79:64], offset_y[95:80],
  // out_red[103:96], out_green[111:104], out_blue[119:112]
  output logic [119:0] out_tdata,
  // last_vertex
  output logic         out_tlast
);

  pqe_pkg::pqe_cmd_t cmd;
  pqe_pkg::pqe_sts_t sts;

  pqe_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .line_start (in_tuser),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pqe_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== dv/polyline_to_quad_strip_expander_checker.sv =====
// ----------------------------------------------------------------------------
// polyline_to_quad_strip_expander_checker
// Watches both channels, predicts the six quad vertices of every segment and
// compares each vertex taken from the block with the oldest prediction.
// ----------------------------------------------------------------------------
module polyline_to_quad_strip_expander_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [87:0]  in_tdata,
  input  logic         in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [119:0] out_tdata,
  input  logic         out_tlast,
  output int           fail_count,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        last;
    logic [7:0]  b;
    logic [7:0]  g;
    logic [7:0]  r;
    logic [15:0] oy;
    logic [15:0] ox;
    logic [31:0] y;
    logic [31:0] x;
  } vertex_t;

  vertex_t     vertex_q[$];
  logic [31:0] held_x, held_y;
  logic        held_valid;

  assign pending = vertex_q.size();

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] res, bit_m;
    res = 0;
    bit_m = 64'd1 << 62;
    while (bit_m > v) bit_m = bit_m >> 2;
    while (bit_m != 0) begin
      if (v >= res + bit_m) begin
        v = v - (res + bit_m);
        res = (res >> 1) + bit_m;
      end else begin
        res = res >> 1;
      end
      bit_m = bit_m >> 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] unit_comp(logic neg, logic [63:0] a, logic [63:0] len);
    logic [63:0] q;
    q = (a * 64'd16384 + len / 2) / len;
    if (q > 64'd16384) q = 64'd16384;
    return neg ? -q[15:0] : q[15:0];
  endfunction

  task automatic predict_segment(logic [31:0] qx, logic [31:0] qy, logic [23:0] rgb);
    logic signed [32:0] dx, dy;
    logic [63:0] ax, ay, len;
    logic [15:0] nx, ny;
    vertex_t v;
    dx = $signed({qx[31], qx}) - $signed({held_x[31], held_x});
    dy = $signed({qy[31], qy}) - $signed({held_y[31], held_y});
    ax = dx < 0 ? 64'(-dx) : 64'(dx);
    ay = dy < 0 ? 64'(-dy) : 64'(dy);
    while (ax >= 64'h8000_0000 || ay >= 64'h8000_0000) begin
      ax = ax >> 1;
      ay = ay >> 1;
    end
    len = isqrt(ax * ax + ay * ay);
    nx = 0;
    ny = 0;
    if (len != 0) begin
      nx = unit_comp(dy < 0, ay, len);
      ny = unit_comp(dx > 0, ax, len);
    end
    for (int k = 0; k < 6; k++) begin
      logic at_q, neg;
      at_q = (k == 1 || k == 4 || k == 5);
      neg = (k == 0 || k == 3 || k == 5);
      v.x = at_q ? qx : held_x;
      v.y = at_q ? qy : held_y;
      v.ox = neg ? -nx : nx;
      v.oy = neg ? -ny : ny;
      v.r = rgb[7:0];
      v.g = rgb[15:8];
      v.b = rgb[23:16];
      v.last = (k == 5);
      vertex_q = {vertex_q, v};
    end
  endtask

  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h actual %h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      held_x <= 0;
      held_y <= 0;
      held_valid <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (!in_tuser && held_valid)
          predict_segment(in_tdata[31:0], in_tdata[63:32], in_tdata[87:64]);
        held_x <= in_tdata[31:0];
        held_y <= in_tdata[63:32];
        held_valid <= 1'b1;
      end
      if (out_tvalid && out_tready) begin
        if (vertex_q.size() == 0) begin
          $error("vertex with no request pending");
          fail_count++;
        end else begin
          vertex_t e;
          e = vertex_q.pop_front();
          compare_field("vert_x", e.x, out_tdata[31:0]);
          compare_field("vert_y", e.y, out_tdata[63:32]);
          compare_field("offset_x", e.ox, out_tdata[79:64]);
          compare_field("offset_y", e.oy, out_tdata[95:80]);
          compare_field("out_red", e.r, out_tdata[103:96]);
          compare_field("out_green", e.g, out_tdata[111:104]);
          compare_field("out_blue", e.b, out_tdata[119:112]);
          compare_field("last_vertex", e.last, out_tlast);
        end
      end
    end
  end
endmodule

// ===== dv/polyline_to_quad_strip_expander_core_test.sv =====
// ----------------------------------------------------------------------------
// polyline_to_quad_strip_expander_core_test
// Drives polyline points with random gaps and output stalls; the checker
// predicts and compares every vertex.
// ----------------------------------------------------------------------------
module polyline_to_quad_strip_expander_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [87:0]  in_tdata = 0;
  logic         in_tuser = 0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [119:0] out_tdata;
  logic         out_tlast;
  int           fail_count, pending;
  bit           quiet = 0;

  always #5 clk = ~clk;

  polyline_to_quad_strip_expander_core dut (.*);

  polyline_to_quad_strip_expander_checker chk (.*);

  // Receiver: stalls about a quarter of cycles except in the quiet stretch.
  always @(posedge clk) out_tready <= quiet || ($urandom_range(99) >= 26);

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(8000)) - 4000);
      default: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
    endcase
  endfunction

  // tvalid stays high after an accept; the next call either replaces the
  // request in the same step or drops tvalid while idling
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic start, logic [23:0] rgb);
    while (!quiet && $urandom_range(99) < 26) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {rgb, y, x};
    in_tuser <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // continuation right after reset opens a line
    send_point(32'd100, 32'd200, 0, 24'h000000);
    send_point(32'd356, 32'd200, 0, 24'hffffff);
    send_point(32'd356, 32'd200, 0, 24'h123456);   // zero length
    send_point(32'd356, 32'd456, 0, 24'habcdef);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 1, 24'h0);
    send_point(32'h8000_0000, 32'h8000_0000, 0, 24'hff00ff);
    send_point(32'h7fff_ffff, 32'h8000_0000, 0, 24'h00ff00);
    send_point(32'h8000_0000, 32'h7fff_ffff, 0, 24'h0000ff);
    send_point(32'hffff_ffff, 32'h0, 1, 24'h1);
    send_point(32'h0, 32'hffff_ffff, 0, 24'h2);
    send_point(32'd0, 32'd0, 0, 24'h3);
    send_point(32'd3, 32'd1, 0, 24'h4);
    // everything out before the random part
    drain();
    for (int i = 0; i < 210; i++) begin
      int mode;
      quiet = (i >= 80 && i < 110);
      mode = $urandom_range(9) < 6 ? 1 : ($urandom_range(3) == 0 ? 2 : 0);
      send_point(rand_coord(mode), rand_coord(mode), $urandom_range(9) == 0,
                 24'($urandom()));
      if (i == 150) drain();
    end
    quiet = 0;
    drain();
    if (fail_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
